@@ rtl/tom_pkg.sv @@
`default_nettype none

package tom_pkg;

	// Q2.14 unity
	localparam int unsigned ONE_Q14 = 16384;

	// Accumulator widths
	localparam int unsigned PROD_W = 40;
	localparam int unsigned ABS_W  = 26;
	localparam int unsigned MAG_W  = 17;

	// Quotient has at most 17 significant bits once the range check has passed
	localparam int unsigned DIV_STEPS = 17;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// Pair queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// Finished row-pair sums handed from the front to the divider
	typedef struct packed {
		logic [PROD_W-1:0] prod_sum;
		logic [ABS_W-1:0]  a_sum;
		logic [ABS_W-1:0]  b_sum;
		logic [15:0]       aij;
	} pair_job_t;

	// Queue status seen by its producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DEN,
		ST_LOAD,
		ST_CHECK,
		ST_DIV,
		ST_OUT
	} div_state_t;

	// Magnitude of a 16-bit two's complement value
	function automatic logic [MAG_W-1:0] mag16(logic [15:0] x);
		logic [MAG_W-1:0] r;
		if (x[15]) begin
			r = 17'h10000 - {1'b0, x};
		end else begin
			r = {1'b0, x};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tom_queue.sv @@
`default_nettype none

module tom_queue import tom_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire pair_job_t push_data,
	input  wire logic      pop,
	output pair_job_t      head,
	output queue_stat_t    stat
);

	pair_job_t        mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

@@ rtl/tom_front.sv @@
`default_nettype none

module tom_front import tom_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] row_a_weight,
	input  wire logic [15:0] row_b_weight,
	input  wire logic [15:0] direct_weight,
	input  wire logic        last_element,
	input  wire queue_stat_t qstat,
	output logic             push,
	output pair_job_t        push_data
);

	logic              valid_s1;
	logic [MAG_W-1:0]  ma_s1;
	logic [MAG_W-1:0]  mb_s1;
	logic [MAG_W-1:0]  prod_s1;
	logic              last_s1;
	logic [15:0]       aij_s1;

	logic [PROD_W-1:0] prod_acc_q;
	logic [ABS_W-1:0]  a_acc_q;
	logic [ABS_W-1:0]  b_acc_q;

	logic [MAG_W-1:0]  ma;
	logic [MAG_W-1:0]  mb;
	logic [30:0]       prod_full;
	logic [30:0]       prod_rnd;
	logic              adv;
	logic [PROD_W:0]   psum;
	logic [ABS_W:0]    asum;
	logic [ABS_W:0]    bsum;
	logic [PROD_W-1:0] psat;
	logic [ABS_W-1:0]  asat;
	logic [ABS_W-1:0]  bsat;

	// Stage 1: magnitudes and rounded product
	assign ma        = mag16(row_a_weight);
	assign mb        = mag16(row_b_weight);
	assign prod_full = {14'b0, ma} * {14'b0, mb};
	assign prod_rnd  = prod_full + 31'd8192;

	// A last element needs a free queue slot before it can retire
	assign adv      = !last_s1 || !qstat.full;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ma_s1   <= ma;
			mb_s1   <= mb;
			prod_s1 <= prod_rnd[30:14];
			last_s1 <= last_element;
			aij_s1  <= direct_weight;
		end
	end

	// Stage 2: saturating accumulation
	assign psum = {1'b0, prod_acc_q} + {24'b0, prod_s1};
	assign asum = {1'b0, a_acc_q} + {10'b0, ma_s1};
	assign bsum = {1'b0, b_acc_q} + {10'b0, mb_s1};
	assign psat = psum[PROD_W] ? '1 : psum[PROD_W-1:0];
	assign asat = asum[ABS_W] ? '1 : asum[ABS_W-1:0];
	assign bsat = bsum[ABS_W] ? '1 : bsum[ABS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_acc_q <= '0;
			a_acc_q    <= '0;
			b_acc_q    <= '0;
		end else if (valid_s1 && adv) begin
			if (last_s1) begin
				prod_acc_q <= '0;
				a_acc_q    <= '0;
				b_acc_q    <= '0;
			end else begin
				prod_acc_q <= psat;
				a_acc_q    <= asat;
				b_acc_q    <= bsat;
			end
		end
	end

	// Hand the finished sums to the divider
	assign push               = valid_s1 && last_s1 && !qstat.full;
	assign push_data.prod_sum = psat;
	assign push_data.a_sum    = asat;
	assign push_data.b_sum    = bsat;
	assign push_data.aij      = aij_s1;

endmodule

`default_nettype wire

@@ rtl/tom_div.sv @@
`default_nettype none

module tom_div import tom_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire queue_stat_t qstat,
	input  wire pair_job_t   head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      overlap_value,
	output logic             saturated,
	output logic             divide_fault
);

	div_state_t         st_q;
	div_state_t         st_d;

	logic [ABS_W-1:0]   kk_q;
	logic [PROD_W:0]    num_q;
	logic [MAG_W-1:0]   amag_q;
	logic               pos_q;
	logic [ABS_W:0]     den_q;
	logic               fault_q;
	logic [55:0]        rem_q;
	logic [42:0]        dsh_q;
	logic [MAG_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               big_q;

	logic               out_valid_q;
	logic [15:0]        value_q;
	logic               sat_q;
	logic               flt_q;

	logic [MAG_W-1:0]   head_mag;
	logic [ABS_W:0]     kk_one;
	logic               den_fault;
	logic [42:0]        lim;
	logic               ge;
	logic               out_free;
	logic [MAG_W-1:0]   neg_quo;
	logic [15:0]        res_value;
	logic               res_sat;

	assign head_mag  = mag16(head.aij);
	assign kk_one    = {1'b0, kk_q} + (ABS_W+1)'(ONE_Q14);
	assign den_fault = kk_one <= {10'b0, amag_q};
	// 32769 * den: a quotient above 32768 saturates either sign
	assign lim       = {1'b0, den_q, 15'b0} + {16'b0, den_q};
	assign ge        = rem_q >= {13'b0, dsh_q};
	assign out_free  = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					pop  = 1'b1;
					st_d = ST_PREP;
				end
			end
			ST_PREP:  st_d = ST_DEN;
			ST_DEN:   st_d = den_fault ? ST_OUT : ST_LOAD;
			ST_LOAD:  st_d = ST_CHECK;
			ST_CHECK: st_d = (rem_q >= {13'b0, lim}) ? ST_OUT : ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					st_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Division datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					kk_q    <= (head.a_sum < head.b_sum) ? head.a_sum : head.b_sum;
					num_q   <= {1'b0, head.prod_sum} + {24'b0, head_mag};
					amag_q  <= head_mag;
					pos_q   <= !head.aij[15] && (head.aij != '0);
				end
			end
			ST_PREP: begin
				fault_q <= 1'b0;
				big_q   <= 1'b0;
			end
			ST_DEN: begin
				fault_q <= den_fault;
				den_q   <= kk_one - {10'b0, amag_q};
			end
			ST_LOAD: begin
				rem_q <= {1'b0, num_q, 14'b0} + {30'b0, den_q[ABS_W:1]};
			end
			ST_CHECK: begin
				big_q <= rem_q >= {13'b0, lim};
				dsh_q <= {den_q, 16'b0};
				quo_q <= '0;
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
			ST_DIV: begin
				if (ge) begin
					rem_q <= rem_q - {13'b0, dsh_q};
				end
				quo_q <= {quo_q[MAG_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sign and clamp
	assign neg_quo = 17'h0 - quo_q;
	always_comb begin
		res_value = '0;
		res_sat   = 1'b0;
		if (fault_q) begin
			res_value = '0;
		end else if (big_q) begin
			res_value = pos_q ? 16'h7fff : 16'h8000;
			res_sat   = 1'b1;
		end else if (pos_q) begin
			if (quo_q > 17'd32767) begin
				res_value = 16'h7fff;
				res_sat   = 1'b1;
			end else begin
				res_value = quo_q[15:0];
			end
		end else begin
			res_value = neg_quo[15:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free) begin
			value_q <= res_value;
			sat_q   <= res_sat;
			flt_q   <= fault_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign overlap_value = value_q;
	assign saturated     = sat_q;
	assign divide_fault  = flt_q;

endmodule

`default_nettype wire

@@ rtl/topological_overlap_pair_core.sv @@
// Signed topological overlap of two adjacency rows.
// Input channel (in_valid/in_ready): one transaction carries one element of each
// row; last_element marks the final pair and samples direct_weight.
// Output channel (out_valid/out_ready): one transaction per row pair with the
// Q2.14 overlap, a saturated flag and a divide_fault flag.
// Throughput: the front takes one element per cycle unless a last element finds
// the queue full. Each row pair then occupies the shared restoring divider for
// setup, range check, 17 quotient steps and output; a two-entry queue lets the
// front keep accumulating the next pairs meanwhile, so rows no shorter than the
// divider's work per pair stream at one element per cycle; shorter rows are
// limited by the divider. A divide fault skips the division and a quotient far
// out of range skips the quotient steps, so both reach out_valid sooner.
// Reset clears the accumulators, the queue and out_valid.
// When the receiver stalls the result holds in the output register, the divider
// finishes one more pair, the queue fills, and then a last element drops in_ready.

`default_nettype none

module topological_overlap_pair_core import tom_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] row_a_weight,
	input  wire logic [15:0] row_b_weight,
	input  wire logic [15:0] direct_weight,
	input  wire logic        last_element,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      overlap_value,
	output logic             saturated,
	output logic             divide_fault
);

	queue_stat_t qstat;
	pair_job_t   push_data;
	pair_job_t   head;
	logic        push;
	logic        pop;

	tom_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.row_a_weight  (row_a_weight),
		.row_b_weight  (row_b_weight),
		.direct_weight (direct_weight),
		.last_element  (last_element),
		.qstat         (qstat),
		.push          (push),
		.push_data     (push_data)
	);

	tom_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	tom_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.qstat         (qstat),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.overlap_value (overlap_value),
		.saturated     (saturated),
		.divide_fault  (divide_fault)
	);

endmodule

`default_nettype wire

@@ bench/topological_overlap_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the overlap core, predicts each row-pair result and
// compares it against the output transactions in order.
module topological_overlap_checker import tom_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [15:0] row_a_weight,
	input  wire logic [15:0] row_b_weight,
	input  wire logic [15:0] direct_weight,
	input  wire logic        last_element,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [15:0] overlap_value,
	input  wire logic        saturated,
	input  wire logic        divide_fault,
	output int               mismatch_count,
	output int               overlaps_due
);

	localparam logic [63:0] LIJ_CAP = (64'd1 << PROD_W) - 64'd1;
	localparam logic [63:0] K_CAP   = (64'd1 << ABS_W) - 64'd1;

	typedef struct packed {
		logic [15:0] value;
		logic        sat;
		logic        fault;
	} overlap_t;

	// Running sums of the current row pair
	logic [PROD_W-1:0] lij_sum;
	logic [ABS_W-1:0]  ka_sum;
	logic [ABS_W-1:0]  kb_sum;

	overlap_t owed_overlaps[$];

	function automatic logic [16:0] weight_mag(logic [15:0] w);
		logic signed [16:0] s;
		s = $signed({w[15], w});
		return (s < 0) ? -s : s;
	endfunction

	function automatic logic [63:0] capped_add(logic [63:0] acc, logic [63:0] add,
			logic [63:0] cap);
		logic [63:0] s;
		s = acc + add;
		return (s > cap) ? cap : s;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [63:0] ma, mb, prod, kk, aij_mag, num, den, q;
		overlap_t want, got;
		if (!arst_n) begin
			lij_sum = '0;
			ka_sum = '0;
			kb_sum = '0;
			owed_overlaps.delete();
			mismatch_count = 0;
			overlaps_due <= 0;
		end else begin
			// Output transaction against the oldest prediction
			if (out_valid && out_ready) begin
				got = '{overlap_value, saturated, divide_fault};
				if (owed_overlaps.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual value=%h sat=%b fault=%b",
						$time, got.value, got.sat, got.fault);
					mismatch_count++;
				end else begin
					want = owed_overlaps.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: overlap_value expected %h actual %h",
							$time, want.value, got.value);
						mismatch_count++;
					end
					if (got.sat !== want.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$time, want.sat, got.sat);
						mismatch_count++;
					end
					if (got.fault !== want.fault) begin
						$display("%0t: divide_fault expected %b actual %b",
							$time, want.fault, got.fault);
						mismatch_count++;
					end
				end
			end

			// Input transaction: accumulate, and on the last element predict
			if (in_valid && in_ready) begin
				ma = 64'(weight_mag(row_a_weight));
				mb = 64'(weight_mag(row_b_weight));
				prod = (ma * mb + 64'd8192) >> 14;
				lij_sum = PROD_W'(capped_add(64'(lij_sum), prod, LIJ_CAP));
				ka_sum = ABS_W'(capped_add(64'(ka_sum), ma, K_CAP));
				kb_sum = ABS_W'(capped_add(64'(kb_sum), mb, K_CAP));

				if (last_element) begin
					kk = 64'((ka_sum < kb_sum) ? ka_sum : kb_sum);
					aij_mag = 64'(weight_mag(direct_weight));
					want = '{16'h0000, 1'b0, 1'b0};
					if (kk + ONE_Q14 <= aij_mag) begin
						want.fault = 1'b1;
					end else begin
						den = kk + ONE_Q14 - aij_mag;
						num = 64'(lij_sum) + aij_mag;
						// round to nearest, half up
						q = ((num << 14) + (den >> 1)) / den;
						if ($signed(direct_weight) > 0) begin
							if (q > 64'd32767) begin
								q = 64'd32767;
								want.sat = 1'b1;
							end
							want.value = q[15:0];
						end else begin
							// zero weight counts as negative
							if (q > 64'd32768) begin
								q = 64'd32768;
								want.sat = 1'b1;
							end
							want.value = 16'(-q);
						end
					end
					owed_overlaps.push_back(want);
					lij_sum = '0;
					ka_sum = '0;
					kb_sum = '0;
				end
			end
			overlaps_due <= owed_overlaps.size();
		end
	end

endmodule

@@ bench/topological_overlap_pair_core_tb.sv @@
`timescale 1ns / 1ps

module topological_overlap_pair_core_tb;

	localparam int RANDOM_ITEMS = 930;
	localparam int OVERFLOW_LEN = 200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {W_FULL, W_SMALL, W_CORNER, W_ZERO} weight_mix_t;
	typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_HALF, READY_RARE} ready_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [15:0] row_a_weight = '0;
	logic [15:0] row_b_weight = '0;
	logic [15:0] direct_weight = '0;
	logic        last_element = 1'b0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [15:0] overlap_value;
	logic        saturated;
	logic        divide_fault;

	int mismatch_count;
	int overlaps_due;
	int cycle_count = 0;
	int burst_left = 0;

	topological_overlap_pair_core i_dut (.*);

	topological_overlap_checker i_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: picks a new random stall pattern for each random span
	initial begin : receiver
		ready_mode_t mode;
		int span;
		forever begin
			mode = ready_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(posedge clk);
				case (mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				READY_HALF:   out_ready <= ($urandom_range(0, 1) != 0);
				default:      out_ready <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	function automatic logic [15:0] pick_weight(weight_mix_t mix);
		case (mix)
		W_FULL:  return 16'($urandom);
		W_SMALL: return 16'($urandom_range(0, 1024) - 512);
		W_ZERO:  return 16'h0000;
		default: begin
			case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return 16'h0000;
			3:       return 16'hffff;
			4:       return 16'h0001;
			5:       return 16'h4000;
			6:       return 16'hc000;
			default: return 16'h8001;
			endcase
		end
		endcase
	endfunction

	// One input transaction, called at a rising edge; returns at the accepting edge
	task automatic push_element(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] aij, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				// idle with junk on the payload
				in_valid <= 1'b0;
				row_a_weight <= 16'($urandom);
				row_b_weight <= 16'($urandom);
				direct_weight <= 16'($urandom);
				last_element <= 1'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		row_a_weight <= a;
		row_b_weight <= b;
		direct_weight <= aij;
		last_element <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic push_row(input int len, input weight_mix_t mix, input logic [15:0] aij);
		for (int i = 1; i <= len; i++) begin
			push_element(pick_weight(mix), pick_weight(mix),
				(i == len) ? aij : 16'($urandom), i == len);
		end
	endtask

	initial begin : stimulus
		int random_items;
		int len;
		weight_mix_t mix;
		logic [15:0] aij;

		random_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, sign of zero weight, saturation and divide faults
		push_element(16'h7fff, 16'h7fff, 16'h4000, 1'b1);
		push_element(16'h8000, 16'h8000, 16'h8000, 1'b1);
		push_element(16'h4000, 16'h4000, 16'h0000, 1'b1);
		push_element(16'h0000, 16'h0000, 16'h4000, 1'b1);
		push_element(16'h0000, 16'h0000, 16'h3fff, 1'b1);
		push_element(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
		push_element(16'h0000, 16'h0000, 16'h0001, 1'b1);
		push_element(16'hffff, 16'h0001, 16'h8000, 1'b0);
		push_element(16'h8001, 16'h7fff, 16'h7fff, 1'b0);
		push_element(16'h1234, 16'hedcb, 16'hffff, 1'b1);
		push_element(16'h0000, 16'h0000, 16'h8000, 1'b1);
		push_element(16'hc000, 16'h4000, 16'hc000, 1'b1);
		push_element(16'h5555, 16'haaaa, 16'h0000, 1'b0);
		push_element(16'haaaa, 16'h5555, 16'hc001, 1'b1);

		// Long row of full-scale weights: large sums and a clamped quotient
		for (int i = 1; i <= OVERFLOW_LEN; i++) begin
			push_element(16'h8000, 16'h8000,
				(i == OVERFLOW_LEN) ? 16'h4000 : 16'($urandom), i == OVERFLOW_LEN);
		end

		// Random row pairs, mostly short
		while (random_items < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
				: $urandom_range(1, 40);
			mix = weight_mix_t'($urandom_range(0, 3));
			case ($urandom_range(0, 3))
			0:       aij = 16'($urandom);
			1:       aij = pick_weight(W_CORNER);
			2:       aij = pick_weight(W_SMALL);
			default: aij = 16'($urandom_range(16000, 16800)) ^ {$urandom_range(0, 1) ? 16'hffff
				: 16'h0000};
			endcase
			push_row(len, mix, aij);
			random_items += len;
		end
		in_valid <= 1'b0;

		// Drain
		@(posedge clk);
		while (overlaps_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && overlaps_due == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			if (overlaps_due != 0)
				$display("%0d expected results never arrived", overlaps_due);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
